// ===== rtl/sbtc_pkg.sv =====
package sbtc_pkg;

    // Default sizes
    localparam int POINT_DEPTH_DEF = 1024;
    localparam int FACE_DEPTH_DEF  = 1024;
    localparam int COORD_WIDTH_DEF = 32;

    // Fixed port widths
    localparam int IN_WIDTH    = 32;
    localparam int INDEX_WIDTH = 10;
    localparam int CNT_WIDTH   = 11;
    localparam int CFG_AW      = 3;

    // Input item operations
    typedef enum logic [1:0] {
        OP_POINT = 2'd0,
        OP_FACE  = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] REG_BOX_MIN_X  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_BOX_MIN_Y  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_BOX_MIN_Z  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_BOX_MAX_X  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_BOX_MAX_Y  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_BOX_MAX_Z  = 3'd5;
    localparam logic [CFG_AW-1:0] REG_FACE_COUNT = 3'd6;

    // Query sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWAP,
        ST_SUM,
        ST_SORT,
        ST_WALK
    } state_t;

endpackage

// ===== rtl/sbtc_ram.sv =====
module sbtc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/swept_box_triangle_collision_core.sv =====
// Query: a query transfer runs the sequencer through swap, sum and sort, then walks the n
// faces in use; the walk ends early when a hit is found, and done marks its end.
// Throughput: one face per cycle through the face RAM then the point RAMs; one query
// at a time. Point and face loads never raise busy.
// Reset (rst_n, async, active low) clears the sequencer and all config registers;
// table contents are undefined until written. The receiver cannot stall done.
module swept_box_triangle_collision_core #(
    parameter int POINT_DEPTH = sbtc_pkg::POINT_DEPTH_DEF,
    parameter int FACE_DEPTH  = sbtc_pkg::FACE_DEPTH_DEF,
    parameter int COORD_WIDTH = sbtc_pkg::COORD_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          op,
    input  logic [sbtc_pkg::INDEX_WIDTH-1:0]    index,
    input  logic signed [sbtc_pkg::IN_WIDTH-1:0] a_x,
    input  logic signed [sbtc_pkg::IN_WIDTH-1:0] a_y,
    input  logic signed [sbtc_pkg::IN_WIDTH-1:0] a_z,
    input  logic signed [sbtc_pkg::IN_WIDTH-1:0] b_x,
    input  logic signed [sbtc_pkg::IN_WIDTH-1:0] b_y,
    input  logic signed [sbtc_pkg::IN_WIDTH-1:0] b_z,
    // result
    output logic                                done,
    output logic                                collided,
    // configuration
    input  logic                                cfg_we,
    input  logic [sbtc_pkg::CFG_AW-1:0]         cfg_addr,
    input  logic [sbtc_pkg::IN_WIDTH-1:0]       cfg_wdata
);

    localparam int CW     = COORD_WIDTH;
    localparam int SW     = (CW > sbtc_pkg::IN_WIDTH ? CW : sbtc_pkg::IN_WIDTH) + 1;
    localparam int PIDX_W = $clog2(POINT_DEPTH);
    localparam int FIDX_W = (FACE_DEPTH > 1) ? $clog2(FACE_DEPTH) : 1;
    localparam int N_W    = $clog2(FACE_DEPTH + 1);
    localparam int FACE_W = 3 * PIDX_W + 1;
    localparam int PT_W   = 3 * CW;

    localparam logic signed [SW-1:0] SAT_HI = (SW'(1) << (CW - 1)) - SW'(1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[CW-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[CW-1:0];
        end
        else
        begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [CW-1:0] coord_in(
        input logic signed [sbtc_pkg::IN_WIDTH-1:0] v
    );
        return sat(SW'(v));
    endfunction

    function automatic logic signed [CW-1:0] min3(
        input logic signed [CW-1:0] p0,
        input logic signed [CW-1:0] p1,
        input logic signed [CW-1:0] p2
    );
        logic signed [CW-1:0] m;
        m = (p0 < p1) ? p0 : p1;
        return (p2 < m) ? p2 : m;
    endfunction

    function automatic logic signed [CW-1:0] max3(
        input logic signed [CW-1:0] p0,
        input logic signed [CW-1:0] p1,
        input logic signed [CW-1:0] p2
    );
        logic signed [CW-1:0] m;
        m = (p0 < p1) ? p1 : p0;
        return (p2 > m) ? p2 : m;
    endfunction

    sbtc_pkg::state_t state_reg, state_next;

    // config registers
    logic signed [CW-1:0]             box_min_reg [3];
    logic signed [CW-1:0]             box_max_reg [3];
    logic [sbtc_pkg::CNT_WIDTH-1:0]   face_count_reg;

    // query setup registers
    logic signed [CW-1:0]             s_reg [3];
    logic signed [CW-1:0]             e_reg [3];
    logic signed [CW-1:0]             c0_reg [3];
    logic signed [CW-1:0]             c1_reg [3];
    logic signed [CW-1:0]             lo_reg [3];
    logic signed [CW-1:0]             hi_reg [3];
    logic                             fwd_reg;
    logic [N_W-1:0]                   n_reg;

    // walk pipeline
    logic [N_W-1:0]                   issue_reg;
    logic                             v1_reg, v2_reg, v3_reg;
    logic                             bad2_reg, bad3_reg;
    logic signed [CW-1:0]             tmin_reg [3];
    logic signed [CW-1:0]             tmax_reg [3];
    logic                             hit_reg;
    logic                             done_reg, collided_reg;

    logic                             accept;
    logic                             issuing;
    logic                             walk_done;
    logic                             walking;
    logic [31:0]                      cnt_ext;
    logic [31:0]                      cnt_clamp;

    // memory ports
    logic                             pt_we, face_we;
    logic [PT_W-1:0]                  pt_wdata;
    logic [FACE_W-1:0]                face_wdata, face_rdata;
    logic [PT_W-1:0]                  pt_rdata [3];
    logic [PIDX_W-1:0]                pt_raddr [3];
    logic                             face_bad;
    logic [FACE_W-1:0]                face_rd_q;

    assign accept  = start && !busy;
    assign walking = (state_reg == sbtc_pkg::ST_WALK);
    assign busy    = (state_reg != sbtc_pkg::ST_IDLE);
    assign done    = done_reg;
    assign collided = collided_reg;

    // load paths
    assign pt_we   = accept && (op == sbtc_pkg::OP_POINT) && (32'(index) < 32'(POINT_DEPTH));
    assign face_we = accept && (op == sbtc_pkg::OP_FACE) && (32'(index) < 32'(FACE_DEPTH));
    assign pt_wdata = {coord_in(a_z), coord_in(a_y), coord_in(a_x)};
    assign face_bad = ($unsigned(a_x) >= 32'(POINT_DEPTH))
                   || ($unsigned(a_y) >= 32'(POINT_DEPTH))
                   || ($unsigned(a_z) >= 32'(POINT_DEPTH));
    assign face_wdata = {face_bad, a_z[PIDX_W-1:0], a_y[PIDX_W-1:0], a_x[PIDX_W-1:0]};

    // face count clamped to the table depth
    assign cnt_ext   = 32'(face_count_reg);
    assign cnt_clamp = (cnt_ext > 32'(FACE_DEPTH)) ? 32'(FACE_DEPTH) : cnt_ext;

    // face table
    sbtc_ram #(
        .WIDTH (FACE_W),
        .DEPTH (FACE_DEPTH)
    ) u_face_ram (
        .clk   (clk),
        .we    (face_we),
        .waddr (FIDX_W'(index)),
        .wdata (face_wdata),
        .raddr (FIDX_W'(issue_reg)),
        .rdata (face_rdata)
    );

    assign face_rd_q = face_rdata;

    // three copies of the point table, one per vertex
    for (genvar v = 0; v < 3; v++)
    begin : g_pt
        assign pt_raddr[v] = face_rd_q[v*PIDX_W +: PIDX_W];

        sbtc_ram #(
            .WIDTH (PT_W),
            .DEPTH (POINT_DEPTH)
        ) u_pt_ram (
            .clk   (clk),
            .we    (pt_we),
            .waddr (PIDX_W'(index)),
            .wdata (pt_wdata),
            .raddr (pt_raddr[v]),
            .rdata (pt_rdata[v])
        );
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbtc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        issuing    = 1'b0;
        walk_done  = 1'b0;
        case (state_reg)
            sbtc_pkg::ST_IDLE:
            begin
                if (accept && (op == sbtc_pkg::OP_QUERY))
                begin
                    state_next = sbtc_pkg::ST_SWAP;
                end
            end
            sbtc_pkg::ST_SWAP: state_next = sbtc_pkg::ST_SUM;
            sbtc_pkg::ST_SUM:  state_next = sbtc_pkg::ST_SORT;
            sbtc_pkg::ST_SORT: state_next = sbtc_pkg::ST_WALK;
            sbtc_pkg::ST_WALK:
            begin
                issuing   = (issue_reg < n_reg) && !hit_reg;
                walk_done = hit_reg
                         || ((issue_reg == n_reg) && !v1_reg && !v2_reg && !v3_reg);
                if (walk_done)
                begin
                    state_next = sbtc_pkg::ST_IDLE;
                end
            end
            default: state_next = sbtc_pkg::ST_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                box_min_reg[a] <= '0;
                box_max_reg[a] <= '0;
            end
            face_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                sbtc_pkg::REG_BOX_MIN_X:  box_min_reg[0] <= coord_in(cfg_wdata);
                sbtc_pkg::REG_BOX_MIN_Y:  box_min_reg[1] <= coord_in(cfg_wdata);
                sbtc_pkg::REG_BOX_MIN_Z:  box_min_reg[2] <= coord_in(cfg_wdata);
                sbtc_pkg::REG_BOX_MAX_X:  box_max_reg[0] <= coord_in(cfg_wdata);
                sbtc_pkg::REG_BOX_MAX_Y:  box_max_reg[1] <= coord_in(cfg_wdata);
                sbtc_pkg::REG_BOX_MAX_Z:  box_max_reg[2] <= coord_in(cfg_wdata);
                sbtc_pkg::REG_FACE_COUNT:
                    face_count_reg <= cfg_wdata[sbtc_pkg::CNT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // swept box setup: capture, direction pick, offset sums, per-axis sort
    always_ff @(posedge clk)
    begin
        if (accept && (op == sbtc_pkg::OP_QUERY))
        begin
            s_reg[0] <= coord_in(a_x);
            s_reg[1] <= coord_in(a_y);
            s_reg[2] <= coord_in(a_z);
            e_reg[0] <= coord_in(b_x);
            e_reg[1] <= coord_in(b_y);
            e_reg[2] <= coord_in(b_z);
            n_reg    <= N_W'(cnt_clamp);
        end
        if (state_reg == sbtc_pkg::ST_SWAP)
        begin
            fwd_reg <= (s_reg[0] < e_reg[0]) || (s_reg[1] < e_reg[1])
                    || (s_reg[2] < e_reg[2]);
        end
        for (int a = 0; a < 3; a++)
        begin
            if (state_reg == sbtc_pkg::ST_SUM)
            begin
                c0_reg[a] <= sat(SW'(fwd_reg ? s_reg[a] : e_reg[a]) + SW'(box_min_reg[a]));
                c1_reg[a] <= sat(SW'(fwd_reg ? e_reg[a] : s_reg[a]) + SW'(box_max_reg[a]));
            end
            if (state_reg == sbtc_pkg::ST_SORT)
            begin
                lo_reg[a] <= (c0_reg[a] < c1_reg[a]) ? c0_reg[a] : c1_reg[a];
                hi_reg[a] <= (c0_reg[a] < c1_reg[a]) ? c1_reg[a] : c0_reg[a];
            end
        end
    end

    // face bounds stage
    always_ff @(posedge clk)
    begin
        bad2_reg <= face_rd_q[FACE_W-1];
        bad3_reg <= bad2_reg;
        for (int a = 0; a < 3; a++)
        begin
            tmin_reg[a] <= min3(pt_rdata[0][a*CW +: CW], pt_rdata[1][a*CW +: CW],
                                pt_rdata[2][a*CW +: CW]);
            tmax_reg[a] <= max3(pt_rdata[0][a*CW +: CW], pt_rdata[1][a*CW +: CW],
                                pt_rdata[2][a*CW +: CW]);
        end
    end

    // walk control, overlap test and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg    <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            hit_reg      <= 1'b0;
            done_reg     <= 1'b0;
            collided_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= issuing;
            v2_reg   <= v1_reg && walking;
            v3_reg   <= v2_reg && walking;
            done_reg <= walk_done;
            if (accept && (op == sbtc_pkg::OP_QUERY))
            begin
                issue_reg <= '0;
                hit_reg   <= 1'b0;
            end
            else
            begin
                if (issuing)
                begin
                    issue_reg <= issue_reg + N_W'(1);
                end
                if (walking && v3_reg && !bad3_reg
                    && (lo_reg[0] < tmax_reg[0]) && (hi_reg[0] > tmin_reg[0])
                    && (lo_reg[1] < tmax_reg[1]) && (hi_reg[1] > tmin_reg[1])
                    && (lo_reg[2] < tmax_reg[2]) && (hi_reg[2] > tmin_reg[2]))
                begin
                    hit_reg <= 1'b1;
                end
            end
            if (walk_done)
            begin
                collided_reg <= hit_reg;
            end
        end
    end

endmodule

// ===== rtl/sbtc_checker.sv =====
module sbtc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] op,
    input logic       done
);

    // a query keeps the core busy after its transfer
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == sbtc_pkg::OP_QUERY)) |=> busy)
        else $error("query transfer did not raise busy");

    // loads and unused codes finish without raising busy
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op != sbtc_pkg::OP_QUERY)) |=> !busy)
        else $error("load transfer raised busy");

    // every finished query shows its result as busy drops
    a_done_on_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // results only appear while idle, one cycle each
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held two cycles");

endmodule

bind swept_box_triangle_collision_core sbtc_checker u_sbtc_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .op    (op),
    .done  (done)
);

// ===== verif/tb_swept_box_triangle_collision_core.sv =====
`timescale 1ns / 100ps

module tb_swept_box_triangle_collision_core;

    localparam int TB_POINTS = sbtc_pkg::POINT_DEPTH_DEF;
    localparam int TB_FACES  = sbtc_pkg::FACE_DEPTH_DEF;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_ITEMS = 41;

    // codes the package leaves out
    localparam logic [1:0]                  OP_UNUSED = 2'd3;
    localparam logic [sbtc_pkg::CFG_AW-1:0] REG_SPARE = 3'd7;

    // Q16.16 values
    localparam logic signed [31:0] CMAX    = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] CMIN    = 32'sh8000_0000;
    localparam logic signed [31:0] ONE     = 32'sh0001_0000;
    localparam logic signed [31:0] HALF    = 32'sh0000_8000;
    localparam logic signed [31:0] QUARTER = 32'sh0000_4000;

    typedef logic signed [31:0] coord3_t [3];

    // directed stimulus row; register rows carry the address in idx and data in ax
    typedef struct packed {
        logic        is_reg;
        logic [1:0]  op;
        logic [9:0]  idx;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        logic [31:0] bx;
        logic [31:0] by;
        logic [31:0] bz;
        logic        typed;
        logic        typed_val;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] op = '0;
    logic [sbtc_pkg::INDEX_WIDTH-1:0] index = '0;
    logic signed [sbtc_pkg::IN_WIDTH-1:0] a_x = '0;
    logic signed [sbtc_pkg::IN_WIDTH-1:0] a_y = '0;
    logic signed [sbtc_pkg::IN_WIDTH-1:0] a_z = '0;
    logic signed [sbtc_pkg::IN_WIDTH-1:0] b_x = '0;
    logic signed [sbtc_pkg::IN_WIDTH-1:0] b_y = '0;
    logic signed [sbtc_pkg::IN_WIDTH-1:0] b_z = '0;
    logic done;
    logic collided;
    logic cfg_we = 1'b0;
    logic [sbtc_pkg::CFG_AW-1:0] cfg_addr = '0;
    logic [sbtc_pkg::IN_WIDTH-1:0] cfg_wdata = '0;

    // mirror of the block: hitbox offsets, walk length, tables
    logic signed [31:0] off_lo [3];
    logic signed [31:0] off_hi [3];
    logic [sbtc_pkg::CNT_WIDTH-1:0] walk_count;
    logic signed [31:0] pnt [TB_POINTS][3];
    logic [31:0] face_vtx [TB_FACES][3];
    bit pnt_written [TB_POINTS];
    bit face_written [TB_FACES];
    int unsigned pnt_list [$];

    bit verdict_q [$];
    int unsigned fail_cnt = 0;
    int unsigned stall_cycles = 0;
    bit idle_off = 1'b0;
    stim_row_t dir_rows [$];

    always #4 clk = ~clk;

    swept_box_triangle_collision_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .index     (index),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .done      (done),
        .collided  (collided),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // saturating Q16.16 add
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] x,
                                                   input logic signed [31:0] y);
        longint t;
        t = longint'(x) + longint'(y);
        if (t > 64'sh0000_0000_7FFF_FFFF)
            return CMAX;
        if (t < -64'sh0000_0000_8000_0000)
            return CMIN;
        return t[31:0];
    endfunction

    // per-axis vertex bounds of one face against the box, strict overlap
    function automatic bit face_overlaps(input int unsigned f, input coord3_t lo,
                                         input coord3_t hi);
        logic signed [31:0] p0, p1, p2, tmin, tmax;
        if (face_vtx[f][0] >= TB_POINTS || face_vtx[f][1] >= TB_POINTS ||
            face_vtx[f][2] >= TB_POINTS)
            return 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            p0 = pnt[face_vtx[f][0]][a];
            p1 = pnt[face_vtx[f][1]][a];
            p2 = pnt[face_vtx[f][2]][a];
            tmin = (p0 < p1) ? p0 : p1;
            tmax = (p0 < p1) ? p1 : p0;
            if (p2 < tmin)
                tmin = p2;
            if (p2 > tmax)
                tmax = p2;
            if (lo[a] >= tmax || hi[a] <= tmin)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // swept box from start/end plus hitbox, then walk the faces in use
    function automatic bit swept_box_hits(input coord3_t s, input coord3_t e);
        coord3_t first, second, lo, hi;
        logic signed [31:0] c0, c1;
        int unsigned n;
        if (s[0] < e[0] || s[1] < e[1] || s[2] < e[2])
        begin
            first = s;
            second = e;
        end
        else
        begin
            first = e;
            second = s;
        end
        for (int a = 0; a < 3; a++)
        begin
            c0 = sat_add(first[a], off_lo[a]);
            c1 = sat_add(second[a], off_hi[a]);
            lo[a] = (c0 < c1) ? c0 : c1;
            hi[a] = (c0 < c1) ? c1 : c0;
        end
        n = (walk_count > TB_FACES) ? TB_FACES : walk_count;
        for (int unsigned f = 0; f < n; f++)
            if (face_overlaps(f, lo, hi))
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void apply_reg(input logic [sbtc_pkg::CFG_AW-1:0] addr,
                                      input logic [31:0] data);
        case (addr)
            sbtc_pkg::REG_BOX_MIN_X:  off_lo[0] = data;
            sbtc_pkg::REG_BOX_MIN_Y:  off_lo[1] = data;
            sbtc_pkg::REG_BOX_MIN_Z:  off_lo[2] = data;
            sbtc_pkg::REG_BOX_MAX_X:  off_hi[0] = data;
            sbtc_pkg::REG_BOX_MAX_Y:  off_hi[1] = data;
            sbtc_pkg::REG_BOX_MAX_Z:  off_hi[2] = data;
            sbtc_pkg::REG_FACE_COUNT: walk_count = data[sbtc_pkg::CNT_WIDTH-1:0];
            default: ;
        endcase
    endfunction

    // update the mirror for one accepted transfer
    function automatic void apply_item(input logic [1:0] o, input logic [9:0] ix,
                                       input logic [31:0] ax, ay, az, bx, by, bz,
                                       input bit typed, input bit typed_val);
        case (o)
            sbtc_pkg::OP_POINT:
            begin
                pnt[ix][0] = ax;
                pnt[ix][1] = ay;
                pnt[ix][2] = az;
                if (!pnt_written[ix])
                    pnt_list.push_back(32'(ix));
                pnt_written[ix] = 1'b1;
            end
            sbtc_pkg::OP_FACE:
            begin
                face_vtx[ix][0] = ax;
                face_vtx[ix][1] = ay;
                face_vtx[ix][2] = az;
                face_written[ix] = 1'b1;
            end
            sbtc_pkg::OP_QUERY:
                verdict_q.push_back(typed ? typed_val
                                          : swept_box_hits('{ax, ay, az}, '{bx, by, bz}));
            default: ;
        endcase
    endfunction

    function automatic stim_row_t mk_item(input logic [1:0] o, input logic [9:0] ix,
                                          input logic [31:0] ax, ay, az, bx, by, bz,
                                          input bit typed, input bit typed_val);
        stim_row_t r;
        r.is_reg = 1'b0;
        r.op = o;
        r.idx = ix;
        r.ax = ax;
        r.ay = ay;
        r.az = az;
        r.bx = bx;
        r.by = by;
        r.bz = bz;
        r.typed = typed;
        r.typed_val = typed_val;
        return r;
    endfunction

    function automatic stim_row_t mk_reg(input logic [sbtc_pkg::CFG_AW-1:0] addr,
                                         input logic [31:0] data);
        stim_row_t r;
        r = mk_item(sbtc_pkg::OP_QUERY, 10'(addr), data, '0, '0, '0, '0, '0, 1'b0, 1'b0);
        r.is_reg = 1'b1;
        return r;
    endfunction

    // random Q16.16: mostly within +-16.0, sometimes extremes or anything
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return CMAX;
            2: return CMIN;
            default: return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        endcase
    endfunction

    function automatic logic signed [31:0] jitter();
        return int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endfunction

    function automatic logic signed [31:0] extreme_coord();
        case ($urandom_range(0, 2))
            0: return CMAX;
            1: return CMIN;
            default: return '0;
        endcase
    endfunction

    // vertex index: a point already loaded, or now and then one out of range
    function automatic logic [31:0] pick_vertex();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(32'hFFFF_FFFF, TB_POINTS);
        return pnt_list[$urandom_range(0, pnt_list.size() - 1)];
    endfunction

    // one command transfer, with idle cycles in front now and then
    task automatic send_item(input logic [1:0] o, input logic [9:0] ix,
                             input logic [31:0] ax, ay, az, bx, by, bz,
                             input bit typed, input bit typed_val);
        if (!idle_off)
        begin
            while ($urandom_range(0, 99) < 24)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        op <= o;
        index <= ix;
        a_x <= ax;
        a_y <= ay;
        a_z <= az;
        b_x <= bx;
        b_y <= by;
        b_z <= bz;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_item(o, ix, ax, ay, az, bx, by, bz, typed, typed_val);
    endtask

    // register write once the block has gone quiet
    task automatic write_reg(input logic [sbtc_pkg::CFG_AW-1:0] addr, input logic [31:0] data);
        start <= 1'b0;
        while (verdict_q.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        apply_reg(addr, data);
        cfg_we <= 1'b0;
    endtask

    // every face a query may walk is written if it was not yet
    task automatic fill_faces(input logic [sbtc_pkg::CNT_WIDTH-1:0] fc);
        int unsigned m;
        m = (fc > TB_FACES) ? TB_FACES : fc;
        for (int unsigned f = 0; f < m; f++)
            if (!face_written[f])
                send_item(sbtc_pkg::OP_FACE, 10'(f), pick_vertex(), pick_vertex(),
                          pick_vertex(), $urandom(), $urandom(), $urandom(), 1'b0, 1'b0);
    endtask

    task automatic send_query();
        coord3_t s, e;
        int unsigned p, mode;
        mode = $urandom_range(0, 9);
        p = pnt_list[$urandom_range(0, pnt_list.size() - 1)];
        for (int a = 0; a < 3; a++)
        begin
            case (mode)
                0, 1, 2, 3, 4:
                begin
                    s[a] = sat_add(pnt[p][a], jitter());
                    e[a] = sat_add(s[a], jitter());
                end
                5, 6:
                begin
                    s[a] = rand_coord();
                    e[a] = sat_add(s[a], jitter());
                end
                7:
                begin
                    s[a] = sat_add(pnt[p][a], jitter());
                    e[a] = s[a];
                end
                8:
                begin
                    s[a] = extreme_coord();
                    e[a] = extreme_coord();
                end
                default:
                begin
                    s[a] = $urandom();
                    e[a] = $urandom();
                end
            endcase
        end
        send_item(sbtc_pkg::OP_QUERY, 10'($urandom()), s[0], s[1], s[2], e[0], e[1], e[2],
                  1'b0, 1'b0);
    endtask

    // result check against the oldest pending verdict
    always @(posedge clk)
    begin
        bit want;
        if (rst_n && done)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("collided: expected none, actual %0b", collided);
                fail_cnt++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (collided !== want)
                begin
                    $error("collided: expected %0b, actual %0b", want, collided);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic [sbtc_pkg::CNT_WIDTH-1:0] fc_plan [12];
        logic signed [31:0] lo_v [3];
        logic signed [31:0] hi_v [3];
        int unsigned n_items, n_sent, sel;

        for (int a = 0; a < 3; a++)
        begin
            off_lo[a] = '0;
            off_hi[a] = '0;
        end
        walk_count = '0;

        // reset state, zero faces: queries must miss
        dir_rows.push_back(mk_item(sbtc_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0));
        dir_rows.push_back(mk_item(sbtc_pkg::OP_QUERY, 10'h3FF, CMAX, CMAX, CMAX,
                                   CMIN, CMIN, CMIN, 1'b1, 1'b0));
        dir_rows.push_back(mk_item(sbtc_pkg::OP_QUERY, 0, CMIN, CMIN, CMIN,
                                   CMAX, CMAX, CMAX, 1'b1, 1'b0));
        // unused op code, all ones
        dir_rows.push_back(mk_item(OP_UNUSED, 10'h3FF, '1, '1, '1, '1, '1, '1, 1'b0, 1'b0));
        // small scene plus points at both extremes
        dir_rows.push_back(mk_item(sbtc_pkg::OP_POINT, 0, 0, 0, 0, '1, '1, '1, 1'b0, 1'b0));
        dir_rows.push_back(mk_item(sbtc_pkg::OP_POINT, 1, ONE, 0, 0, 0, 0, 0, 1'b0, 1'b0));
        dir_rows.push_back(mk_item(sbtc_pkg::OP_POINT, 2, 0, ONE, 0, 0, 0, 0, 1'b0, 1'b0));
        dir_rows.push_back(mk_item(sbtc_pkg::OP_POINT, 3, 0, 0, ONE, 0, 0, 0, 1'b0, 1'b0));
        dir_rows.push_back(mk_item(sbtc_pkg::OP_POINT, 10'd1023, CMAX, CMAX, CMAX, 0, 0, 0,
                                   1'b0, 1'b0));
        dir_rows.push_back(mk_item(sbtc_pkg::OP_POINT, 10'd1022, CMIN, CMIN, CMIN, 0, 0, 0,
                                   1'b0, 1'b0));
        dir_rows.push_back(mk_item(sbtc_pkg::OP_FACE, 0, 1, 2, 3, 0, 0, 0, 1'b0, 1'b0));
        // vertex index out of range, far and just past the end, and a face on the extreme points
        dir_rows.push_back(mk_item(sbtc_pkg::OP_FACE, 1, 32'hFFFF_FFFF, 1, 2, 0, 0, 0,
                                   1'b0, 1'b0));
        dir_rows.push_back(mk_item(sbtc_pkg::OP_FACE, 2, 1023, 1022, 0, 0, 0, 0, 1'b0, 1'b0));
        dir_rows.push_back(mk_item(sbtc_pkg::OP_FACE, 3, TB_POINTS, 0, 1, 0, 0, 0,
                                   1'b0, 1'b0));
        // +-0.5 hitbox, one face; index past the register list is ignored
        dir_rows.push_back(mk_reg(sbtc_pkg::REG_BOX_MIN_X, -HALF));
        dir_rows.push_back(mk_reg(sbtc_pkg::REG_BOX_MIN_Y, -HALF));
        dir_rows.push_back(mk_reg(sbtc_pkg::REG_BOX_MIN_Z, -HALF));
        dir_rows.push_back(mk_reg(sbtc_pkg::REG_BOX_MAX_X, HALF));
        dir_rows.push_back(mk_reg(sbtc_pkg::REG_BOX_MAX_Y, HALF));
        dir_rows.push_back(mk_reg(sbtc_pkg::REG_BOX_MAX_Z, HALF));
        dir_rows.push_back(mk_reg(sbtc_pkg::REG_FACE_COUNT, 1));
        dir_rows.push_back(mk_reg(REG_SPARE, '1));
        dir_rows.push_back(mk_item(sbtc_pkg::OP_QUERY, 0, QUARTER, QUARTER, QUARTER,
                                   QUARTER, QUARTER, QUARTER, 1'b0, 1'b0));
        dir_rows.push_back(mk_item(sbtc_pkg::OP_QUERY, 0, 5 * ONE, 5 * ONE, 5 * ONE,
                                   6 * ONE, 6 * ONE, 6 * ONE, 1'b0, 1'b0));
        // box edge touching the face bound: strict compare must miss
        dir_rows.push_back(mk_item(sbtc_pkg::OP_QUERY, 0, -HALF, -HALF, -HALF,
                                   -HALF, -HALF, -HALF, 1'b0, 1'b0));
        // start above end on x, equal elsewhere: corners swap roles
        dir_rows.push_back(mk_item(sbtc_pkg::OP_QUERY, 0, 2 * ONE, 0, 0, 0, 0, 0,
                                   1'b0, 1'b0));
        dir_rows.push_back(mk_reg(sbtc_pkg::REG_FACE_COUNT, 4));
        dir_rows.push_back(mk_item(sbtc_pkg::OP_QUERY, 0, CMAX, CMAX, CMAX,
                                   CMAX, CMAX, CMAX, 1'b0, 1'b0));
        dir_rows.push_back(mk_item(sbtc_pkg::OP_QUERY, 0, CMIN, CMIN, CMIN,
                                   CMIN, CMIN, CMIN, 1'b0, 1'b0));
        // hitbox at the extremes, sums saturate
        dir_rows.push_back(mk_reg(sbtc_pkg::REG_BOX_MIN_X, CMIN));
        dir_rows.push_back(mk_reg(sbtc_pkg::REG_BOX_MIN_Y, CMIN));
        dir_rows.push_back(mk_reg(sbtc_pkg::REG_BOX_MIN_Z, CMIN));
        dir_rows.push_back(mk_reg(sbtc_pkg::REG_BOX_MAX_X, CMAX));
        dir_rows.push_back(mk_reg(sbtc_pkg::REG_BOX_MAX_Y, CMAX));
        dir_rows.push_back(mk_reg(sbtc_pkg::REG_BOX_MAX_Z, CMAX));
        dir_rows.push_back(mk_reg(sbtc_pkg::REG_FACE_COUNT, 2));
        dir_rows.push_back(mk_item(sbtc_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
        dir_rows.push_back(mk_item(sbtc_pkg::OP_QUERY, 0, CMAX, CMAX, CMAX,
                                   CMIN, CMIN, CMIN, 1'b0, 1'b0));
        // face count past the table depth; face zero hits and ends the walk
        dir_rows.push_back(mk_reg(sbtc_pkg::REG_FACE_COUNT, 32'h0000_07FF));
        dir_rows.push_back(mk_item(sbtc_pkg::OP_QUERY, 0, 0, 0, 0, ONE, ONE, ONE,
                                   1'b0, 1'b0));

        fc_plan = '{11'd3, 11'd0, 11'd8, 11'd1, 11'd12, 11'd5,
                    11'd20, 11'd6, 11'd16, 11'd10, 11'd2, 11'd7};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_reg)
                write_reg(dir_rows[i].idx[sbtc_pkg::CFG_AW-1:0], dir_rows[i].ax);
            else
                send_item(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].ax, dir_rows[i].ay,
                          dir_rows[i].az, dir_rows[i].bx, dir_rows[i].by, dir_rows[i].bz,
                          dir_rows[i].typed, dir_rows[i].typed_val);
        end

        // random phases, each with its own hitbox and face count
        for (int ph = 0; ph < 12; ph++)
        begin
            idle_off = (ph == 2) || (ph == 9);
            for (int a = 0; a < 3; a++)
            begin
                case (ph)
                    4:
                    begin
                        lo_v[a] = CMIN;
                        hi_v[a] = CMAX;
                    end
                    7:
                    begin
                        lo_v[a] = CMAX;
                        hi_v[a] = CMIN;
                    end
                    10:
                    begin
                        lo_v[a] = int'($urandom_range(0, 32'h0002_0000));
                        hi_v[a] = -int'($urandom_range(0, 32'h0002_0000));
                    end
                    default:
                    begin
                        lo_v[a] = -int'($urandom_range(0, 32'h0002_0000));
                        hi_v[a] = int'($urandom_range(0, 32'h0002_0000));
                    end
                endcase
            end
            write_reg(sbtc_pkg::REG_BOX_MIN_X, lo_v[0]);
            write_reg(sbtc_pkg::REG_BOX_MIN_Y, lo_v[1]);
            write_reg(sbtc_pkg::REG_BOX_MIN_Z, lo_v[2]);
            write_reg(sbtc_pkg::REG_BOX_MAX_X, hi_v[0]);
            write_reg(sbtc_pkg::REG_BOX_MAX_Y, hi_v[1]);
            write_reg(sbtc_pkg::REG_BOX_MAX_Z, hi_v[2]);
            write_reg(sbtc_pkg::REG_FACE_COUNT,
                      ($urandom() & 32'hFFFF_F800) | 32'(fc_plan[ph]));
            if (ph % 3 == 0)
                write_reg(REG_SPARE, $urandom());
            fill_faces(fc_plan[ph]);

            n_items = PHASE_ITEMS;
            n_sent = 0;
            while (n_sent < n_items)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 8)
                    send_item(OP_UNUSED, 10'($urandom()), $urandom(), $urandom(),
                              $urandom(), $urandom(), $urandom(), $urandom(), 1'b0, 1'b0);
                else
                begin
                    n_sent++;
                    if (sel < 55)
                        send_query();
                    else if (sel < 78)
                        send_item(sbtc_pkg::OP_POINT, 10'($urandom()), rand_coord(),
                                  rand_coord(), rand_coord(), $urandom(), $urandom(),
                                  $urandom(), 1'b0, 1'b0);
                    else
                        send_item(sbtc_pkg::OP_FACE, 10'($urandom()), pick_vertex(),
                                  pick_vertex(), pick_vertex(), $urandom(), $urandom(),
                                  $urandom(), 1'b0, 1'b0);
                end
            end
        end

        // drain
        start <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== swept_box_triangle_collision_core.f =====
rtl/sbtc_pkg.sv
rtl/sbtc_ram.sv
rtl/swept_box_triangle_collision_core.sv
rtl/sbtc_checker.sv
verif/tb_swept_box_triangle_collision_core.sv
